>>> rtl/core/b32enc_pkg.sv
// Shared types, constants and polymod helpers for the Bech32 string encoder.
package b32enc_pkg;

    typedef enum logic [1:0] {
        K_PREFIX = 2'd0,
        K_DATA   = 2'd1,
        K_END    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] pchar;
        logic [4:0] dval;
    } t_cmd;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       error;
    } t_res;

    typedef enum logic [3:0] {
        ST_RUN,
        ST_HI_RD,
        ST_HI_STEP,
        ST_ZERO,
        ST_LO_RD,
        ST_LO_STEP,
        ST_SEP,
        ST_FOLD,
        ST_CSUM
    } t_bstate;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam logic [29:0] RESID_INIT = 30'd1;
    localparam logic [6:0]  SEP_CHAR   = 7'h31;
    localparam logic [2:0]  SYM_LAST   = 3'd5;

    localparam logic [29:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    localparam logic [6:0] SYM_CHARS [32] = '{
        7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
        7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
        7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
        7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
    };

    function automatic logic [29:0] poly_step(logic [29:0] r, logic [4:0] v);
        logic [29:0] n;
        n = {r[24:0], v};
        for (int k = 0; k < 5; k++) begin
            if (r[25 + k]) begin
                n = n ^ GEN[k];
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] sym_char(logic [4:0] v);
        return SYM_CHARS[v];
    endfunction

endpackage

>>> rtl/core/b32enc_fifo.sv
// Small register-based queue with push/pop handshakes.
module b32enc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/b32enc_front.sv
// Front end: accepts input items, decodes the action and queues commands.
module b32enc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [1:0]          i_action,
    input  logic [6:0]          i_prefix_char,
    input  logic [4:0]          i_data_value,
    output logic                o_full,
    output logic                o_cmd_vld,
    output b32enc_pkg::t_cmd    o_cmd,
    input  logic                i_cmd_pop
);

    b32enc_pkg::t_cmd w_cmd;
    logic             w_known;
    logic             w_q_empty;

    always_comb begin
        w_cmd.pchar = i_prefix_char;
        w_cmd.dval  = i_data_value;
        w_known     = 1'b1;
        unique case (i_action)
            b32enc_pkg::K_PREFIX: w_cmd.kind = b32enc_pkg::K_PREFIX;
            b32enc_pkg::K_DATA:   w_cmd.kind = b32enc_pkg::K_DATA;
            b32enc_pkg::K_END:    w_cmd.kind = b32enc_pkg::K_END;
            default: begin
                // drop unknown actions
                w_cmd.kind = b32enc_pkg::K_PREFIX;
                w_known    = 1'b0;
            end
        endcase
    end

    b32enc_fifo #(
        .W     ($bits(b32enc_pkg::t_cmd)),
        .DEPTH (b32enc_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_known),
        .i_data  (w_cmd),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_full  (o_full),
        .o_empty (w_q_empty)
    );

    assign o_cmd_vld = !w_q_empty;

endmodule

>>> rtl/core/b32enc_back.sv
// Back end: prefix store, polymod sequencer and result generation.
module b32enc_back #(
    parameter int PREFIX_MAX = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_vld,
    input  b32enc_pkg::t_cmd    i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output b32enc_pkg::t_res    o_res
);

    localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
    localparam int CW = $clog2(PREFIX_MAX + 1);

    b32enc_pkg::t_bstate r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [2:0]          r_sym, n_sym;
    logic [29:0]         r_resid, n_resid;
    logic                r_data_phase, n_data_phase;
    logic [6:0]          r_store [PREFIX_MAX];
    logic [6:0]          r_rd_q;
    logic                w_store_wr;
    logic                w_idx_last;
    logic [29:0]         w_fold;

    assign w_idx_last = (CW'(r_idx + 1'b1) == r_count);
    assign w_fold     = b32enc_pkg::poly_step(r_resid, 5'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b32enc_pkg::ST_RUN: begin
                if (i_cmd_vld && i_cmd.kind != b32enc_pkg::K_PREFIX) begin
                    if (!r_data_phase) begin
                        n_state = (r_count != '0) ? b32enc_pkg::ST_HI_RD
                                                  : b32enc_pkg::ST_ZERO;
                    end else if (i_cmd.kind == b32enc_pkg::K_END) begin
                        n_state = b32enc_pkg::ST_FOLD;
                    end
                end
            end
            b32enc_pkg::ST_HI_RD:   n_state = b32enc_pkg::ST_HI_STEP;
            b32enc_pkg::ST_HI_STEP: begin
                n_state = w_idx_last ? b32enc_pkg::ST_ZERO : b32enc_pkg::ST_HI_RD;
            end
            b32enc_pkg::ST_ZERO: begin
                n_state = (r_count != '0) ? b32enc_pkg::ST_LO_RD : b32enc_pkg::ST_SEP;
            end
            b32enc_pkg::ST_LO_RD:   n_state = b32enc_pkg::ST_LO_STEP;
            b32enc_pkg::ST_LO_STEP: begin
                n_state = w_idx_last ? b32enc_pkg::ST_SEP : b32enc_pkg::ST_LO_RD;
            end
            b32enc_pkg::ST_SEP: begin
                if (!i_res_full) begin
                    n_state = b32enc_pkg::ST_RUN;
                end
            end
            b32enc_pkg::ST_FOLD: begin
                if (r_sym == b32enc_pkg::SYM_LAST) begin
                    n_state = b32enc_pkg::ST_CSUM;
                end
            end
            b32enc_pkg::ST_CSUM: begin
                if (!i_res_full && r_sym == b32enc_pkg::SYM_LAST) begin
                    n_state = b32enc_pkg::ST_RUN;
                end
            end
            default: n_state = b32enc_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_sym        = r_sym;
        n_resid      = r_resid;
        n_data_phase = r_data_phase;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        w_store_wr   = 1'b0;
        unique case (r_state)
            b32enc_pkg::ST_RUN: begin
                if (i_cmd_vld) begin
                    unique case (i_cmd.kind)
                        b32enc_pkg::K_PREFIX: begin
                            if (!i_res_full) begin
                                o_res_push = 1'b1;
                                o_cmd_pop  = 1'b1;
                                if (r_data_phase || r_count == CW'(PREFIX_MAX)) begin
                                    o_res.error = 1'b1;
                                end else begin
                                    o_res.ch   = i_cmd.pchar;
                                    w_store_wr = 1'b1;
                                    n_count    = r_count + 1'b1;
                                end
                            end
                        end
                        b32enc_pkg::K_DATA: begin
                            n_idx = '0;
                            if (r_data_phase && !i_res_full) begin
                                o_res_push = 1'b1;
                                o_cmd_pop  = 1'b1;
                                o_res.ch   = b32enc_pkg::sym_char(i_cmd.dval);
                                n_resid    = b32enc_pkg::poly_step(r_resid, i_cmd.dval);
                            end
                        end
                        b32enc_pkg::K_END: begin
                            n_idx = '0;
                            n_sym = '0;
                        end
                        default: n_idx = r_idx;
                    endcase
                end
            end
            b32enc_pkg::ST_HI_STEP: begin
                n_resid = b32enc_pkg::poly_step(r_resid, {3'b000, r_rd_q[6:5]});
                n_idx   = w_idx_last ? '0 : r_idx + 1'b1;
            end
            b32enc_pkg::ST_ZERO: begin
                n_resid = w_fold;
                n_idx   = '0;
            end
            b32enc_pkg::ST_LO_STEP: begin
                n_resid = b32enc_pkg::poly_step(r_resid, r_rd_q[4:0]);
                n_idx   = w_idx_last ? '0 : r_idx + 1'b1;
            end
            b32enc_pkg::ST_SEP: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.ch     = b32enc_pkg::SEP_CHAR;
                    n_data_phase = 1'b1;
                end
            end
            b32enc_pkg::ST_FOLD: begin
                if (r_sym == b32enc_pkg::SYM_LAST) begin
                    n_resid = w_fold ^ 30'd1;
                    n_sym   = '0;
                end else begin
                    n_resid = w_fold;
                    n_sym   = r_sym + 1'b1;
                end
            end
            b32enc_pkg::ST_CSUM: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.ch   = b32enc_pkg::sym_char(r_resid[29:25]);
                    o_res.last = (r_sym == b32enc_pkg::SYM_LAST);
                    n_resid    = {r_resid[24:0], 5'd0};
                    n_sym      = r_sym + 1'b1;
                    if (r_sym == b32enc_pkg::SYM_LAST) begin
                        o_cmd_pop    = 1'b1;
                        n_count      = '0;
                        n_resid      = b32enc_pkg::RESID_INIT;
                        n_data_phase = 1'b0;
                        n_sym        = '0;
                    end
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= b32enc_pkg::ST_RUN;
            r_count      <= '0;
            r_idx        <= '0;
            r_sym        <= '0;
            r_resid      <= b32enc_pkg::RESID_INIT;
            r_data_phase <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_sym        <= n_sym;
            r_resid      <= n_resid;
            r_data_phase <= n_data_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_store[r_count[AW-1:0]] <= i_cmd.pchar;
        end
        r_rd_q <= r_store[r_idx[AW-1:0]];
    end

endmodule

>>> rtl/core/bech32_string_encoder.sv
// Top level of the Bech32 string encoder: front end, back end and result queue.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------
//   input    | push / full      | i_action, i_prefix_char, i_data_value
//   result   | pop / empty      | o_out_char, o_last, o_error
//
// The first data symbol or end mark runs the N stored prefix characters through the
// polymod in two passes (high bits, a zero symbol, then low bits), each character a
// store read then a polymod step, and then emits the separator. The end mark then
// folds in six zero symbols and emits the six checksum characters.
// Reset is synchronous; no clearing pass, the prefix store is read only below the count.
// A full result queue stalls the back end; a full command queue raises full.
module bech32_string_encoder #(
    parameter int PREFIX_MAX = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic [6:0] i_prefix_char,
    input  logic [4:0] i_data_value,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_out_char,
    output logic       o_last,
    output logic       o_error
);

    b32enc_pkg::t_cmd w_cmd;
    logic             w_cmd_vld;
    logic             w_cmd_pop;
    b32enc_pkg::t_res w_res;
    logic             w_res_push;
    logic             w_res_full;
    b32enc_pkg::t_res w_res_head;

    b32enc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_action      (i_action),
        .i_prefix_char (i_prefix_char),
        .i_data_value  (i_data_value),
        .o_full        (full),
        .o_cmd_vld     (w_cmd_vld),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    b32enc_back #(
        .PREFIX_MAX (PREFIX_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    b32enc_fifo #(
        .W     ($bits(b32enc_pkg::t_res)),
        .DEPTH (b32enc_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_full  (w_res_full),
        .o_empty (empty)
    );

    assign o_out_char = w_res_head.ch;
    assign o_last     = w_res_head.last;
    assign o_error    = w_res_head.error;

`ifndef SYNTH
    a_res_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result transfer into a full queue");

    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_vld)
        else $error("command dropped from an empty queue");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_out_char == 7'd0 && !o_last))
        else $error("error result carries a character or last mark");

    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.last) |-> w_cmd_pop)
        else $error("final checksum character without retiring the end command");
`endif

endmodule

>>> tb/bech32_checker.sv
// Checker for the Bech32 string encoder: predicts each output string and compares every transfer.
`timescale 1ns / 100ps
module bech32_checker #(
    parameter int PREFIX_MAX = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_action,
    input  logic [6:0] i_prefix_char,
    input  logic [4:0] i_data_value,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [6:0] i_out_char,
    input  logic       i_last,
    input  logic       i_error,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [29:0] BCH_GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };
    localparam logic [8*32-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [6:0]  SEPARATOR    = 7'h31;
    localparam logic [6:0]  NO_CHAR      = 7'h00;
    localparam logic [29:0] RESIDUE_SEED = 30'd1;
    localparam int          CSUM_LEN     = 6;

    logic [6:0]         hrp_mem [PREFIX_MAX];
    int unsigned        hrp_len;
    logic [29:0]        residue;
    logic               in_data;
    b32enc_pkg::t_res   string_q [$];

    function automatic logic [29:0] bch_fold(input logic [29:0] acc, input logic [4:0] sym);
        logic [29:0] nxt;
        nxt = {acc[24:0], sym};
        for (int b = 0; b < 5; b++) begin
            if (acc[25 + b]) begin
                nxt = nxt ^ BCH_GEN[b];
            end
        end
        return nxt;
    endfunction

    function automatic logic [6:0] charset_at(input logic [4:0] s);
        return CHARSET[8 * (31 - int'(s)) +: 7];
    endfunction

    task automatic queue_result(input logic [6:0] ch, input logic lst, input logic err);
        b32enc_pkg::t_res r;
        r.ch    = ch;
        r.last  = lst;
        r.error = err;
        string_q.push_back(r);
    endtask

    // walk high bits, a zero, then low bits of the stored prefix
    task automatic close_prefix();
        logic [29:0] acc;
        acc = residue;
        for (int i = 0; i < int'(hrp_len); i++) begin
            acc = bch_fold(acc, {3'b000, hrp_mem[i][6:5]});
        end
        acc = bch_fold(acc, 5'd0);
        for (int i = 0; i < int'(hrp_len); i++) begin
            acc = bch_fold(acc, hrp_mem[i][4:0]);
        end
        residue = acc;
        in_data = 1'b1;
        queue_result(SEPARATOR, 1'b0, 1'b0);
    endtask

    task automatic take_item(input logic [1:0] act, input logic [6:0] pc, input logic [4:0] dv);
        logic [29:0] acc;
        case (act)
            b32enc_pkg::K_PREFIX: begin
                if (in_data || hrp_len >= PREFIX_MAX) begin
                    queue_result(NO_CHAR, 1'b0, 1'b1);
                end else begin
                    hrp_mem[hrp_len] = pc;
                    hrp_len++;
                    queue_result(pc, 1'b0, 1'b0);
                end
            end
            b32enc_pkg::K_DATA: begin
                if (!in_data) begin
                    close_prefix();
                end
                residue = bch_fold(residue, dv);
                queue_result(charset_at(dv), 1'b0, 1'b0);
            end
            b32enc_pkg::K_END: begin
                if (!in_data) begin
                    close_prefix();
                end
                acc = residue;
                repeat (CSUM_LEN) acc = bch_fold(acc, 5'd0);
                acc[0] = ~acc[0];
                for (int i = 0; i < CSUM_LEN; i++) begin
                    queue_result(charset_at(acc[25 - 5 * i +: 5]), i == CSUM_LEN - 1, 1'b0);
                end
                hrp_len = 0;
                residue = RESIDUE_SEED;
                in_data = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        b32enc_pkg::t_res want;
        if (string_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual char %h last %b error %b",
                     $time, i_out_char, i_last, i_error);
            o_fail_count++;
        end else begin
            want = string_q.pop_front();
            if (i_out_char !== want.ch) begin
                $display("%0t: wrong out_char: expected %h actual %h",
                         $time, want.ch, i_out_char);
                o_fail_count++;
            end
            if (i_last !== want.last) begin
                $display("%0t: wrong last: expected %b actual %b", $time, want.last, i_last);
                o_fail_count++;
            end
            if (i_error !== want.error) begin
                $display("%0t: wrong error: expected %b actual %b", $time, want.error, i_error);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hrp_len = 0;
            residue = RESIDUE_SEED;
            in_data = 1'b0;
            string_q.delete();
        end else begin
            if (i_push && !i_full) begin
                take_item(i_action, i_prefix_char, i_data_value);
            end
            if (i_pop && !i_empty) begin
                check_result();
            end
        end
        o_pending = string_q.size();
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the Bech32 string encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam int         PREFIX_MAX   = 128;
    localparam logic [1:0] ACT_IGNORED  = 2'd3;
    localparam int         RANDOM_ITEMS = 460;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         LIMIT_CYCLES = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_action;
    logic [6:0] i_prefix_char;
    logic [4:0] i_data_value;
    logic       empty;
    logic       pop;
    logic [6:0] o_out_char;
    logic       o_last;
    logic       o_error;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left;
    int   sent_count;
    int   rx_tick = 0;
    logic hold_req;

    bech32_string_encoder #(
        .PREFIX_MAX(PREFIX_MAX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_prefix_char (i_prefix_char),
        .i_data_value  (i_data_value),
        .empty         (empty),
        .pop           (pop),
        .o_out_char    (o_out_char),
        .o_last        (o_last),
        .o_error       (o_error)
    );

    bech32_checker #(
        .PREFIX_MAX(PREFIX_MAX)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_action      (i_action),
        .i_prefix_char (i_prefix_char),
        .i_data_value  (i_data_value),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_out_char    (o_out_char),
        .i_last        (o_last),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("bech32_string_encoder: mismatch");
            $finish;
        end
    end

    // receiver: rotate through pop patterns, hold off once on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                rx_tick++;
                case (rx_tick[8:7])
                    2'd0:    pop <= 1'b1;
                    2'd1:    pop <= ($urandom_range(0, 1) == 0);
                    2'd2:    pop <= ($urandom_range(0, 7) != 0);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [6:0] pc, input logic [4:0] dv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        push          <= 1'b1;
        i_action      <= act;
        i_prefix_char <= pc;
        i_data_value  <= dv;
        do @(posedge i_clk); while (full);
        if (act != ACT_IGNORED) begin
            sent_count++;
        end
    endtask

    task automatic send_random(input logic [1:0] act);
        send_item(act, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    endtask

    // hold the input until every predicted character has been transferred
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic send_string();
        int mode;
        int hrp_n;
        int data_n;
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            repeat ($urandom_range(1, 10)) send_random(2'($urandom_range(0, 3)));
        end else begin
            hrp_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
            data_n = $urandom_range(0, 24);
            repeat (hrp_n) send_random(b32enc_pkg::K_PREFIX);
            for (int i = 0; i < data_n; i++) begin
                if (mode >= 7 && $urandom_range(0, 5) == 0) begin
                    send_random(($urandom_range(0, 1) == 0) ? ACT_IGNORED
                                                            : b32enc_pkg::K_PREFIX);
                end
                send_random(b32enc_pkg::K_DATA);
            end
            send_random(b32enc_pkg::K_END);
        end
    endtask

    // close any open string, overrun the prefix buffer, then send a data symbol and an end mark
    task automatic fill_prefix_buffer();
        send_random(b32enc_pkg::K_END);
        repeat (PREFIX_MAX + 2) send_random(b32enc_pkg::K_PREFIX);
        send_random(b32enc_pkg::K_DATA);
        send_random(b32enc_pkg::K_END);
    endtask

    initial begin
        int str_idx;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_action      = b32enc_pkg::K_PREFIX;
        i_prefix_char = 7'h00;
        i_data_value  = 5'h00;
        hold_req      = 1'b0;
        burst_left    = 0;
        sent_count    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(b32enc_pkg::K_END, 7'h00, 5'h00);
        send_item(ACT_IGNORED, 7'h7f, 5'h1f);
        send_item(b32enc_pkg::K_PREFIX, 7'h00, 5'h1f);
        send_item(b32enc_pkg::K_PREFIX, 7'h7f, 5'h00);
        send_item(b32enc_pkg::K_PREFIX, 7'h41, 5'h00);
        send_item(b32enc_pkg::K_DATA, 7'h7f, 5'h00);
        send_item(b32enc_pkg::K_DATA, 7'h00, 5'h1f);
        send_item(b32enc_pkg::K_PREFIX, 7'h55, 5'h00);
        send_item(ACT_IGNORED, 7'h00, 5'h00);
        send_item(b32enc_pkg::K_DATA, 7'h00, 5'h15);
        send_item(b32enc_pkg::K_END, 7'h7f, 5'h1f);
        send_item(b32enc_pkg::K_PREFIX, 7'h62, 5'h00);
        send_item(b32enc_pkg::K_PREFIX, 7'h63, 5'h00);
        send_item(b32enc_pkg::K_END, 7'h00, 5'h00);
        send_item(b32enc_pkg::K_DATA, 7'h00, 5'h0a);
        send_item(b32enc_pkg::K_END, 7'h00, 5'h00);
        drain();

        sent_count = 0;
        str_idx    = 0;
        while (sent_count < RANDOM_ITEMS) begin
            if (str_idx == 3) begin
                fill_prefix_buffer();
            end else begin
                if (str_idx == 6) begin
                    hold_req = 1'b1;
                end
                if ($urandom_range(0, 15) == 0) begin
                    drain();
                end
                send_string();
            end
            str_idx++;
        end
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("bech32_string_encoder: match");
        end else begin
            $display("bech32_string_encoder: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/b32enc_pkg.sv
rtl/core/b32enc_fifo.sv
rtl/core/b32enc_front.sv
rtl/core/b32enc_back.sv
rtl/core/bech32_string_encoder.sv
tb/bech32_checker.sv
tb/tb_top.sv
